@@ design/coulomb_pair_force_accumulator_defines.svh @@
// ----------------------------------------------------------------------------
// Coulomb pair force accumulator assertion macros
// Shared property forms for the checker of the force accumulator.
// ----------------------------------------------------------------------------
`ifndef COULOMB_PAIR_FORCE_ACCUMULATOR_DEFINES_SVH
`define COULOMB_PAIR_FORCE_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define CPFA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("force accumulator check failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define CPFA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("force accumulator check failed");

`endif

@@ design/cpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Coulomb pair force accumulator package
// Shared constants, register codes and the sequencer state type.
// ----------------------------------------------------------------------------
package cpfa_pkg;

	localparam int CPFA_MAX_BODIES = 32;
	localparam int CPFA_ACC_W      = 48;
	localparam int CPFA_DIV_NW     = 80;
	localparam int CPFA_DIV_DW     = 33;
	localparam int CPFA_CFG_IDX_W  = 1;

	localparam logic [31:0] CPFA_COULOMB_RST = 32'd65536;
	localparam logic [31:0] CPFA_DRAG_RST    = 32'd0;
	localparam logic [CPFA_ACC_W-1:0] CPFA_ACC_MAX = {1'b0, {(CPFA_ACC_W-1){1'b1}}};

	typedef enum logic [CPFA_CFG_IDX_W-1:0] {
		CFG_COULOMB_GAIN,
		CFG_DRAG_GAIN
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DRAG_X, ST_DRAG_Y, ST_LOAD_WR,
		ST_ROW, ST_ROW_LATCH, ST_PAIR_RD, ST_PAIR_CHK,
		ST_ABS, ST_SQ_X, ST_SQ_Y, ST_SQRT, ST_RADIUS, ST_AMP,
		ST_U, ST_U_WAIT, ST_M_LO, ST_M_HI, ST_Q1, ST_Q1_WAIT, ST_Q2, ST_Q2_WAIT,
		ST_ACC_A_RD, ST_ACC_A_WR, ST_ACC_B_RD, ST_ACC_B_WR, ST_NEXT,
		ST_OUT_RD, ST_OUT_PUT
	} cpfa_state_t;

endpackage

@@ design/cpfa_div.sv @@
// ----------------------------------------------------------------------------
// Serial restoring divider
// Unsigned quotient of num by den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpfa_div import cpfa_pkg::*; #(
	parameter int NW = CPFA_DIV_NW,
	parameter int DW = CPFA_DIV_DW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quo
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [NW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;
	logic             fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

@@ design/coulomb_pair_force_accumulator.sv @@
// ----------------------------------------------------------------------------
// Coulomb pair force accumulator
// Loads 2-D bodies, sums drag and pairwise Coulomb forces, emits one force
// per body in load order.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  body    | in        | body_valid / body_ready| pos, vel, charge, is_player, last_body
//  force   | out       | force_valid/force_ready| force_x/y, body_index, flagged, last_force
//
// A body load passes ST_DRAG_X, ST_DRAG_Y and ST_LOAD_WR. A computed pair
// runs a serial square root and then the serial divider three times per
// force component; a player-player pair skips the force terms. Each
// force then passes ST_OUT_RD and ST_OUT_PUT, holding while the output stalls.
// Reset clears control state only; stores need no clearing pass.
// A stalled force holds the sequencer until its transfer completes.
// ----------------------------------------------------------------------------
module coulomb_pair_force_accumulator import cpfa_pkg::*; #(
	parameter int MAX_BODIES = CPFA_MAX_BODIES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CPFA_CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]               cfg_data,
	input  logic                      body_valid,
	output logic                      body_ready,
	input  logic signed [31:0]        pos_x,
	input  logic signed [31:0]        pos_y,
	input  logic signed [31:0]        vel_x,
	input  logic signed [31:0]        vel_y,
	input  logic signed [7:0]         charge,
	input  logic                      is_player,
	input  logic                      last_body,
	output logic                      force_valid,
	input  logic                      force_ready,
	output logic signed [31:0]        force_x,
	output logic signed [31:0]        force_y,
	output logic [4:0]                body_index,
	output logic                      flagged,
	output logic                      last_force
);

	localparam int IW = $clog2(MAX_BODIES);
	localparam int CW = $clog2(MAX_BODIES + 1);
	localparam int AW = CPFA_ACC_W;
	localparam int NW = CPFA_DIV_NW;
	localparam int DW = CPFA_DIV_DW;

	cpfa_state_t state_q, state_d;

	logic [31:0] coulomb_q, drag_q;
	logic [CW-1:0] count_q, a_q, b_q, k_q;

	logic [31:0] ld_px_q, ld_py_q, ld_vx_q, ld_vy_q;
	logic [7:0]  ld_q_q;
	logic        ld_kind_q, ld_last_q;
	logic [AW-1:0] drag_x_q, drag_y_q;

	logic [72:0] bmem [MAX_BODIES];
	logic [72:0] bm_rdata_q;
	logic [IW-1:0] bm_raddr;
	logic        bm_we;

	logic [2*AW:0] fmem [MAX_BODIES];
	logic [2*AW:0] fm_rdata_q, fm_wdata;
	logic [IW-1:0] fm_raddr, fm_waddr;
	logic          fm_we;

	logic [31:0] pa_x_q, pa_y_q;
	logic [7:0]  qa_q;
	logic        kinda_q;
	logic [32:0] dx_q, dy_q;
	logic signed [15:0] qq_q;
	logic [31:0] ax_q, ay_q;
	logic        sh_q;
	logic [61:0] sqx_q;
	logic [63:0] rem_q, res_q, bit_q;
	logic [4:0]  step_q;
	logic [DW-1:0] r_q;
	logic [45:0] amp_q;
	logic [33:0] u_q;
	logic [62:0] mlo_q, mhi_q;
	logic        comp_q, big_q;
	logic [AW-1:0] fx_q, fy_q;

	logic          div_start, div_busy;
	logic [NW-1:0] div_num, div_quo;

	logic          out_load, out_valid_q, out_flag_q, out_last_q;
	logic [31:0]   out_x_q, out_y_q;
	logic [4:0]    out_idx_q;

	logic [31:0] abs_x, abs_y;
	logic [30:0] bxv, byv;
	logic [61:0] sq_y;
	logic [63:0] sq_trial;
	logic [14:0] qq_abs;
	logic        q_ovf, t_neg;
	logic [AW-1:0] t_mag, t_term;
	logic [AW-1:0] acc_x, acc_y;
	logic        acc_flag;
	logic        sat_x, sat_y, k_last;
	logic [31:0] sx, sy;
	logic [IW+4:0] kext;

	function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] acc,
		input logic [AW-1:0] d);
		logic [AW:0] s;
		s = {acc[AW-1], acc} + {d[AW-1], d};
		case (s[AW:AW-1])
			2'b01:   sat_add = CPFA_ACC_MAX;
			2'b10:   sat_add = ~CPFA_ACC_MAX;
			default: sat_add = s[AW-1:0];
		endcase
	endfunction

	function automatic logic [AW-1:0] drag_term(input logic [31:0] v, input logic [31:0] g);
		logic [31:0] av;
		logic [63:0] p;
		av = v[31] ? (~v + 32'd1) : v;
		p = g * av;
		drag_term = v[31] ? p[63:16] : (~p[63:16] + AW'(1));
	endfunction

	cpfa_div #(.NW(NW), .DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (r_q),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	assign abs_x  = dx_q[32] ? (~dx_q[31:0] + 32'd1) : dx_q[31:0];
	assign abs_y  = dy_q[32] ? (~dy_q[31:0] + 32'd1) : dy_q[31:0];
	assign bxv    = sh_q ? ax_q[31:1] : ax_q[30:0];
	assign byv    = sh_q ? ay_q[31:1] : ay_q[30:0];
	assign sq_y   = byv * byv;
	assign sq_trial = res_q + bit_q;
	assign qq_abs = qq_q[15] ? 15'(-qq_q) : qq_q[14:0];
	assign q_ovf  = |div_quo[NW-1:AW-1];
	assign t_mag  = q_ovf ? CPFA_ACC_MAX : {1'b0, div_quo[AW-2:0]};
	assign t_neg  = qq_q[15] ^ (comp_q ? dy_q[32] : dx_q[32]);
	assign t_term = t_neg ? (~t_mag + AW'(1)) : t_mag;

	assign acc_x    = fm_rdata_q[2*AW:AW+1];
	assign acc_y    = fm_rdata_q[AW:1];
	assign acc_flag = fm_rdata_q[0];
	assign sat_x  = (acc_x[AW-1:31] != '0) && (acc_x[AW-1:31] != '1);
	assign sat_y  = (acc_y[AW-1:31] != '0) && (acc_y[AW-1:31] != '1);
	assign sx     = sat_x ? (acc_x[AW-1] ? 32'h8000_0000 : 32'h7fff_ffff) : acc_x[31:0];
	assign sy     = sat_y ? (acc_y[AW-1] ? 32'h8000_0000 : 32'h7fff_ffff) : acc_y[31:0];
	assign k_last = (k_q + CW'(1)) == count_q;
	assign kext   = {5'b0, k_q[IW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		body_ready = 1'b0;
		bm_we      = 1'b0;
		fm_we      = 1'b0;
		bm_raddr   = a_q[IW-1:0];
		fm_raddr   = k_q[IW-1:0];
		fm_waddr   = count_q[IW-1:0];
		fm_wdata   = {drag_x_q, drag_y_q, 1'b0};
		div_start  = 1'b0;
		div_num    = div_quo;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				body_ready = 1'b1;
				if (body_valid) begin
					if (count_q < CW'(MAX_BODIES)) begin
						state_d = ST_DRAG_X;
					end else if (last_body) begin
						state_d = ST_ROW;
					end
				end
			end
			ST_DRAG_X: state_d = ST_DRAG_Y;
			ST_DRAG_Y: state_d = ST_LOAD_WR;
			ST_LOAD_WR: begin
				bm_we   = 1'b1;
				fm_we   = 1'b1;
				state_d = ld_last_q ? ST_ROW : ST_IDLE;
			end
			ST_ROW: begin
				if ((a_q + CW'(1)) >= count_q) begin
					state_d = ST_OUT_RD;
				end else begin
					state_d = ST_ROW_LATCH;
				end
			end
			ST_ROW_LATCH: state_d = ST_PAIR_RD;
			ST_PAIR_RD: begin
				bm_raddr = b_q[IW-1:0];
				state_d  = ST_PAIR_CHK;
			end
			ST_PAIR_CHK: state_d = (kinda_q && bm_rdata_q[0]) ? ST_NEXT : ST_ABS;
			ST_ABS:      state_d = ST_SQ_X;
			ST_SQ_X:     state_d = ST_SQ_Y;
			ST_SQ_Y:     state_d = ST_SQRT;
			ST_SQRT: begin
				if (step_q == 5'd31) begin
					state_d = ST_RADIUS;
				end
			end
			ST_RADIUS: state_d = ST_AMP;
			ST_AMP:    state_d = (r_q == '0) ? ST_ACC_A_RD : ST_U;
			ST_U: begin
				div_start = 1'b1;
				div_num   = {16'b0, (comp_q ? ay_q : ax_q), 32'b0};
				state_d   = ST_U_WAIT;
			end
			ST_U_WAIT: begin
				if (!div_busy) begin
					state_d = ST_M_LO;
				end
			end
			ST_M_LO: state_d = ST_M_HI;
			ST_M_HI: state_d = ST_Q1;
			ST_Q1: begin
				div_start = 1'b1;
				div_num   = {17'b0, mlo_q} + {mhi_q, 17'b0};
				state_d   = ST_Q1_WAIT;
			end
			ST_Q1_WAIT: begin
				if (!div_busy) begin
					state_d = ST_Q2;
				end
			end
			ST_Q2: begin
				div_start = 1'b1;
				state_d   = ST_Q2_WAIT;
			end
			ST_Q2_WAIT: begin
				if (!div_busy) begin
					state_d = comp_q ? ST_ACC_A_RD : ST_U;
				end
			end
			ST_ACC_A_RD: begin
				fm_raddr = a_q[IW-1:0];
				state_d  = ST_ACC_A_WR;
			end
			ST_ACC_A_WR: begin
				fm_we    = 1'b1;
				fm_waddr = a_q[IW-1:0];
				fm_wdata = {sat_add(acc_x, fx_q), sat_add(acc_y, fy_q), acc_flag | big_q};
				state_d  = ST_ACC_B_RD;
			end
			ST_ACC_B_RD: begin
				fm_raddr = b_q[IW-1:0];
				state_d  = ST_ACC_B_WR;
			end
			ST_ACC_B_WR: begin
				fm_we    = 1'b1;
				fm_waddr = b_q[IW-1:0];
				fm_wdata = {sat_add(acc_x, ~fx_q + AW'(1)), sat_add(acc_y, ~fy_q + AW'(1)),
					acc_flag | big_q};
				state_d  = ST_NEXT;
			end
			ST_NEXT:   state_d = ((b_q + CW'(1)) < count_q) ? ST_PAIR_RD : ST_ROW;
			ST_OUT_RD: state_d = ST_OUT_PUT;
			ST_OUT_PUT: begin
				if (!out_valid_q || force_ready) begin
					out_load = 1'b1;
					state_d  = k_last ? ST_IDLE : ST_OUT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coulomb_q <= CPFA_COULOMB_RST;
			drag_q    <= CPFA_DRAG_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_COULOMB_GAIN: coulomb_q <= cfg_data;
				CFG_DRAG_GAIN:    drag_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			a_q     <= '0;
			b_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					a_q <= '0;
					k_q <= '0;
				end
				ST_LOAD_WR: begin
					count_q <= count_q + CW'(1);
					a_q     <= '0;
					k_q     <= '0;
				end
				ST_ROW: b_q <= a_q + CW'(1);
				ST_NEXT: begin
					if ((b_q + CW'(1)) < count_q) begin
						b_q <= b_q + CW'(1);
					end else begin
						a_q <= a_q + CW'(1);
					end
				end
				ST_OUT_PUT: begin
					if (out_load) begin
						k_q <= k_q + CW'(1);
						if (k_last) begin
							count_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (body_valid) begin
					ld_px_q   <= pos_x;
					ld_py_q   <= pos_y;
					ld_vx_q   <= vel_x;
					ld_vy_q   <= vel_y;
					ld_q_q    <= charge;
					ld_kind_q <= is_player;
					ld_last_q <= last_body;
				end
			end
			ST_DRAG_X: drag_x_q <= drag_term(ld_vx_q, drag_q);
			ST_DRAG_Y: drag_y_q <= drag_term(ld_vy_q, drag_q);
			ST_ROW_LATCH: begin
				pa_x_q  <= bm_rdata_q[72:41];
				pa_y_q  <= bm_rdata_q[40:9];
				qa_q    <= bm_rdata_q[8:1];
				kinda_q <= bm_rdata_q[0];
			end
			ST_PAIR_CHK: begin
				dx_q <= {pa_x_q[31], pa_x_q} - {bm_rdata_q[72], bm_rdata_q[72:41]};
				dy_q <= {pa_y_q[31], pa_y_q} - {bm_rdata_q[40], bm_rdata_q[40:9]};
				qq_q <= $signed(qa_q) * $signed(bm_rdata_q[8:1]);
			end
			ST_ABS: begin
				ax_q <= abs_x;
				ay_q <= abs_y;
				sh_q <= abs_x[31] | abs_y[31];
			end
			ST_SQ_X: sqx_q <= bxv * bxv;
			ST_SQ_Y: begin
				rem_q  <= {2'b0, sqx_q} + {2'b0, sq_y};
				res_q  <= '0;
				bit_q  <= 64'h4000_0000_0000_0000;
				step_q <= '0;
			end
			ST_SQRT: begin
				if (rem_q >= sq_trial) begin
					rem_q <= rem_q - sq_trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q  <= bit_q >> 2;
				step_q <= step_q + 5'd1;
			end
			ST_RADIUS: r_q <= sh_q ? {res_q[31:0], 1'b0} : {1'b0, res_q[31:0]};
			ST_AMP: begin
				comp_q <= 1'b0;
				if (r_q == '0) begin
					fx_q  <= '0;
					fy_q  <= '0;
					big_q <= 1'b1;
				end else begin
					amp_q <= coulomb_q * qq_abs;
					big_q <= 1'b0;
				end
			end
			ST_U_WAIT: begin
				if (!div_busy) begin
					u_q <= div_quo[33:0];
				end
			end
			ST_M_LO: mlo_q <= amp_q * u_q[16:0];
			ST_M_HI: mhi_q <= amp_q * u_q[33:17];
			ST_Q2_WAIT: begin
				if (!div_busy) begin
					big_q <= big_q | q_ovf;
					if (comp_q) begin
						fy_q <= t_term;
					end else begin
						fx_q   <= t_term;
						comp_q <= 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bmem[count_q[IW-1:0]] <= {ld_px_q, ld_py_q, ld_q_q, ld_kind_q};
		end
		bm_rdata_q <= bmem[bm_raddr];
	end

	always_ff @(posedge clk) begin
		if (fm_we) begin
			fmem[fm_waddr] <= fm_wdata;
		end
		fm_rdata_q <= fmem[fm_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (force_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q    <= sx;
			out_y_q    <= sy;
			out_idx_q  <= kext[4:0];
			out_flag_q <= acc_flag | sat_x | sat_y;
			out_last_q <= k_last;
		end
	end

	assign cfg_ready   = 1'b1;
	assign force_valid = out_valid_q;
	assign force_x     = out_x_q;
	assign force_y     = out_y_q;
	assign body_index  = out_idx_q;
	assign flagged     = out_flag_q;
	assign last_force  = out_last_q;

endmodule

@@ design/cpfa_checker.sv @@
// ----------------------------------------------------------------------------
// Coulomb pair force accumulator checker
// Port-level properties of the force accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "coulomb_pair_force_accumulator_defines.svh"

module cpfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        body_valid,
	input logic        body_ready,
	input logic        last_body,
	input logic        force_valid,
	input logic        force_ready,
	input logic [31:0] force_x,
	input logic [31:0] force_y,
	input logic [4:0]  body_index,
	input logic        last_force
);

	// No body is taken while a run still has forces to deliver.
	`CPFA_ASSERT_IMP(a_no_load_mid_run, force_valid && !last_force, !body_ready)

	// A body transfer that does not close the set never starts a force.
	`CPFA_ASSERT_IMP(a_no_force_after_load, $rose(force_valid), !$past(body_valid && body_ready && !last_body))

	// A stalled force holds its payload.
	`CPFA_ASSERT_NXT(a_force_hold, force_valid && !force_ready, force_valid && $stable(force_x) && $stable(force_y) && $stable(body_index) && $stable(last_force))

endmodule

bind coulomb_pair_force_accumulator cpfa_checker u_cpfa_checker (.*);
